### src/assert_macros.svh
// assertion macros shared by the rewrite break decision rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check with reset masking
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also applies while reset is held
`define RBD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rbd_pkg.sv
// shared widths, constants and types of the rewrite break decision block
// no dependencies; imported by every module of the block
package rbd_pkg;

    localparam int SIZE_W    = 32;
    localparam int SCORE_W   = 16;
    localparam int PROD_W    = SIZE_W + SCORE_W;
    localparam int FACTOR_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int FLAG_W    = 4;
    localparam int DIV_CELLS = SCORE_W;
    localparam int IN_DATA_W = ((4 * SIZE_W + 7) / 8) * 8;

    localparam logic [SCORE_W-1:0]  FULL_SCORE    = SCORE_W'(60000);
    localparam logic [SCORE_W-1:0]  DEFAULT_BREAK = SCORE_W'(30000);
    localparam logic [SCORE_W-1:0]  DEFAULT_MERGE = SCORE_W'(36000);
    localparam logic [SIZE_W-1:0]   MIN_PAIR_SIZE = SIZE_W'(400);
    localparam logic [FACTOR_W-1:0] ADD_FACTOR    = FACTOR_W'(20);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BREAK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MERGE = CFG_IDX_W'(1);

    typedef struct packed {
        logic              eligible;
        logic              same_kind;
        logic              same_content;
        logic              data_error;
        logic [SIZE_W-1:0] src_size;
        logic [SIZE_W-1:0] dst_size;
        logic [SIZE_W-1:0] copied_bytes;
        logic [SIZE_W-1:0] added_bytes;
    } t_item;

    typedef struct packed {
        logic do_break;
        logic full;
    } t_side;

    // p: partial remainder, lq: dividend low bits shifting out, quotient shifting in
    typedef struct packed {
        logic [SIZE_W-1:0]  p;
        logic [SCORE_W-1:0] lq;
        logic [SIZE_W-1:0]  d;
        t_side              side;
    } t_flow;

endpackage

### src/rbd_prep.sv
// front pipeline: clamping, products and the break decision of one pair
// depends on rbd_pkg; feeds the divider cell row
module rbd_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  rbd_pkg::t_item               i_item,
    input  logic [rbd_pkg::SCORE_W-1:0]  i_brk,
    output logic                         o_ready,
    output logic                         o_valid,
    output rbd_pkg::t_flow               o_flow,
    input  logic                         i_ready
);
    import rbd_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // stage 1
    logic               r1_full, r1_eval, n1_full, n1_eval;
    logic [SIZE_W-1:0]  r1_src, r1_dst, r1_max, r1_cpy, r1_add, n1_max, n1_cpy;
    logic [SCORE_W-1:0] r1_brk;
    // stage 2
    logic               r2_full, r2_eval;
    logic [SIZE_W-1:0]  r2_src, r2_max, r2_cpy, r2_add, r2_rem, n2_add;
    logic [SIZE_W:0]    w2_sum;
    logic [SCORE_W-1:0] r2_brk;
    // stage 3
    logic                       r3_full, r3_eval;
    logic [PROD_W-1:0]          r3_rf, r3_sbr, r3_bm, n3_rf, n3_sbr, n3_bm;
    logic [SIZE_W:0]            r3_num;
    logic [SIZE_W+FACTOR_W-1:0] r3_a20, n3_a20;
    logic [SIZE_W-1:0]          r3_rem, r3_cpy, r3_src;
    // stage 4
    logic              r4_full, r4_eval, r4_gt, r4_rm, r4_a, n4_gt, n4_a;
    logic [PROD_W:0]   r4_nf, n4_nf;
    logic [PROD_W-1:0] r4_bm, r4_rf;
    logic [SIZE_W-1:0] r4_src;
    // stage 5
    t_flow r5_flow, n5_flow;
    logic  w5_lt;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v5;
    assign o_flow  = r5_flow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // classify the pair, clamp the copied count
    always_comb begin
        n1_max  = (i_item.src_size > i_item.dst_size) ? i_item.src_size : i_item.dst_size;
        n1_full = i_item.eligible && !i_item.same_kind;
        n1_eval = i_item.eligible && i_item.same_kind && !i_item.same_content &&
                  !i_item.data_error && (n1_max >= MIN_PAIR_SIZE) &&
                  (i_item.src_size != '0);
        n1_cpy  = (i_item.copied_bytes > i_item.src_size) ? i_item.src_size
                                                          : i_item.copied_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_full <= n1_full;
            r1_eval <= n1_eval;
            r1_src  <= i_item.src_size;
            r1_dst  <= i_item.dst_size;
            r1_max  <= n1_max;
            r1_cpy  <= n1_cpy;
            r1_add  <= i_item.added_bytes;
            r1_brk  <= i_brk;
        end
    end

    // clamp the added count against the destination size
    always_comb begin
        w2_sum = {1'b0, r1_add} + {1'b0, r1_cpy};
        if (w2_sum > {1'b0, r1_dst}) begin
            n2_add = (r1_cpy < r1_dst) ? (r1_dst - r1_cpy) : '0;
        end else begin
            n2_add = r1_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r2_full <= r1_full;
            r2_eval <= r1_eval;
            r2_src  <= r1_src;
            r2_max  <= r1_max;
            r2_cpy  <= r1_cpy;
            r2_add  <= n2_add;
            r2_rem  <= r1_src - r1_cpy;
            r2_brk  <= r1_brk;
        end
    end

    // independent products
    always_comb begin
        n3_rf  = r2_rem * FULL_SCORE;
        n3_sbr = r2_src * r2_brk;
        n3_bm  = r2_max * r2_brk;
        n3_a20 = r2_add * ADD_FACTOR;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r3_full <= r2_full;
            r3_eval <= r2_eval;
            r3_rf   <= n3_rf;
            r3_sbr  <= n3_sbr;
            r3_bm   <= n3_bm;
            r3_num  <= {1'b0, r2_rem} + {1'b0, r2_add};
            r3_a20  <= n3_a20;
            r3_rem  <= r2_rem;
            r3_cpy  <= r2_cpy;
            r3_src  <= r2_src;
        end
    end

    // removal score above threshold: removed*full >= src*(threshold+1)
    always_comb begin
        n4_nf = r3_num * FULL_SCORE;
        n4_gt = {1'b0, r3_rf} >= ({1'b0, r3_sbr} + (PROD_W+1)'(r3_src));
        n4_a  = (r3_a20 < (SIZE_W+FACTOR_W)'(r3_rem)) &&
                (r3_a20 < (SIZE_W+FACTOR_W)'(r3_cpy));
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r4_full <= r3_full;
            r4_eval <= r3_eval;
            r4_gt   <= n4_gt;
            r4_rm   <= r3_sbr < r3_rf;
            r4_a    <= n4_a;
            r4_nf   <= n4_nf;
            r4_bm   <= r3_bm;
            r4_rf   <= r3_rf;
            r4_src  <= r3_src;
        end
    end

    // edit ratio below threshold: (removed+added)*full < threshold*max
    always_comb begin
        w5_lt                 = r4_nf < {1'b0, r4_bm};
        n5_flow.p             = r4_rf[PROD_W-1:SCORE_W];
        n5_flow.lq            = r4_rf[SCORE_W-1:0];
        n5_flow.d             = r4_src;
        n5_flow.side.full     = r4_full;
        n5_flow.side.do_break = r4_full ||
                                (r4_eval && (r4_gt || (!w5_lt && !(r4_rm && r4_a))));
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r5_flow <= n5_flow;
        end
    end

endmodule

### src/rbd_div_cell.sv
// one cell of the divider row: resolves one quotient bit per transfer
// depends on rbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rbd_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rbd_pkg::t_flow i_flow,
    output logic           o_ready,
    output logic           o_valid,
    output rbd_pkg::t_flow o_flow,
    input  logic           i_ready
);
    import rbd_pkg::*;

    logic            r_valid;
    t_flow           r_flow, n_flow;
    logic [SIZE_W:0] w_trial, w_diff;
    logic            w_ge;

    always_comb begin
        w_trial     = {i_flow.p, i_flow.lq[SCORE_W-1]};
        w_diff      = w_trial - {1'b0, i_flow.d};
        w_ge        = w_trial >= {1'b0, i_flow.d};
        n_flow      = i_flow;
        n_flow.p    = w_ge ? w_diff[SIZE_W-1:0] : w_trial[SIZE_W-1:0];
        n_flow.lq   = {i_flow.lq[SCORE_W-2:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_flow  = r_flow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_flow <= n_flow;
        end
    end

    `RBD_ASSERT(a_rem_below_div, i_clk, i_rst_n, (r_valid && (r_flow.d != '0)) |-> (r_flow.p < r_flow.d), "partial remainder not below divisor")

endmodule

### src/rewrite_break_decision.sv
// top level of the rewrite break decision block
// depends on rbd_pkg, rbd_prep, rbd_div_cell and assert_macros.svh
//
// usage
//   input stream: one transfer per file pair; tdata carries the four byte
//   counts, tuser the four pair flags. output stream: one transfer per pair,
//   tdata the 16-bit pair score, tuser the break flag. results leave in the
//   order the pairs arrived.
//   configuration: index 0 is the break threshold, index 1 the merge
//   threshold; zero selects the default. write only while no pair is in
//   flight. the port never stalls.
//   pipeline: five front stages, sixteen divider cells, one output register.
//   throughput: one pair per cycle unless the output stalls; the removal
//   score division is spread over the cell row, one quotient bit per cell.
//   reset: all stage valids and both thresholds clear; no result is shown.
//   stall: each stage holds while its successor is full and stalled, so
//   bubbles close up; the input stalls only once every stage holds a pair.
`include "assert_macros.svh"

module rewrite_break_decision (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: src_size, dst_size, copied_bytes, added_bytes
    input  logic [rbd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: eligible, same_kind, same_content, data_error
    input  logic [rbd_pkg::FLAG_W-1:0]     i_s_tuser,
    // output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: pair_score
    output logic [rbd_pkg::SCORE_W-1:0]    o_m_tdata,
    // tuser: do_break
    output logic                           o_m_tuser,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbd_pkg::SCORE_W-1:0]    i_cfg_data
);
    import rbd_pkg::*;

    // threshold registers
    logic [SCORE_W-1:0] r_brk_set, r_mrg_set;
    logic [SCORE_W-1:0] w_brk_eff, w_mrg_eff;

    // item unpacked from the input transfer
    t_item w_item;

    // cell row links; index 0 is the front pipeline output
    t_flow w_flow  [DIV_CELLS+1];
    logic  w_valid [DIV_CELLS+1];
    logic  w_ready [DIV_CELLS+1];

    // output register
    logic               r_out_valid, r_do_break;
    logic [SCORE_W-1:0] r_score, n_score, w_pre;
    logic               w_out_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk_set <= '0;
            r_mrg_set <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BREAK: r_brk_set <= i_cfg_data;
                REG_MERGE: r_mrg_set <= i_cfg_data;
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // zero selects the default thresholds
    assign w_brk_eff = (r_brk_set == '0) ? DEFAULT_BREAK : r_brk_set;
    assign w_mrg_eff = (r_mrg_set == '0) ? DEFAULT_MERGE : r_mrg_set;

    always_comb begin
        w_item.eligible     = i_s_tuser[0];
        w_item.same_kind    = i_s_tuser[1];
        w_item.same_content = i_s_tuser[2];
        w_item.data_error   = i_s_tuser[3];
        w_item.src_size     = i_s_tdata[SIZE_W-1:0];
        w_item.dst_size     = i_s_tdata[2*SIZE_W-1:SIZE_W];
        w_item.copied_bytes = i_s_tdata[3*SIZE_W-1:2*SIZE_W];
        w_item.added_bytes  = i_s_tdata[4*SIZE_W-1:3*SIZE_W];
    end

    // classification, clamping, products and the break decision
    rbd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_item  (w_item),
        .i_brk   (w_brk_eff),
        .o_ready (o_s_tready),
        .o_valid (w_valid[0]),
        .o_flow  (w_flow[0]),
        .i_ready (w_ready[0])
    );

    // divider row: removed * full / src, one quotient bit per cell
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        rbd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_flow  (w_flow[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_flow  (w_flow[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    // kind mismatch takes the full score; low scores and scores of unbroken pairs are zeroed
    always_comb begin
        w_pre   = w_flow[DIV_CELLS].side.full ? FULL_SCORE : w_flow[DIV_CELLS].lq;
        n_score = (w_flow[DIV_CELLS].side.do_break && (w_pre >= w_mrg_eff)) ? w_pre : '0;
    end

    assign w_out_ready        = !r_out_valid || i_m_tready;
    assign w_ready[DIV_CELLS] = w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[DIV_CELLS]) begin
            r_score    <= n_score;
            r_do_break <= w_flow[DIV_CELLS].side.do_break;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_score;
    assign o_m_tuser  = r_do_break;

    `RBD_ASSERT(a_cfg_break_lands, i_clk, i_rst_n, (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_BREAK)) |=> (r_brk_set == $past(i_cfg_data)), "break threshold write lost")
    `RBD_ASSERT(a_score_needs_break, i_clk, i_rst_n, (r_out_valid && !r_do_break) |-> (r_score == '0), "score on a pair that is not broken")
    `RBD_ASSERT_RST(a_reset_clears_out, i_clk, (!i_rst_n) |=> (!r_out_valid), "result shown after reset")

endmodule

### bench/rbd_split_checker.sv
// checker for the rewrite break decision block: watches the pair, result and
// register channels, predicts each pair's verdict and compares it in order
// depends on rbd_pkg
module rbd_split_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // tdata: src_size, dst_size, copied_bytes, added_bytes
    input  logic [rbd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: eligible, same_kind, same_content, data_error
    input  logic [rbd_pkg::FLAG_W-1:0]     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: pair_score
    input  logic [rbd_pkg::SCORE_W-1:0]    i_m_tdata,
    // tuser: do_break
    input  logic                           i_m_tuser,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbd_pkg::SCORE_W-1:0]    i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_splits
);
    import rbd_pkg::*;

    typedef struct packed {
        logic               split;
        logic [SCORE_W-1:0] score;
    } t_split_verdict;

    logic [SCORE_W-1:0] break_setting;
    logic [SCORE_W-1:0] merge_setting;
    t_split_verdict     expected_verdicts[$];
    t_split_verdict     want;
    t_item              pair;
    int                 mismatch_cnt = 0;
    int                 checked_cnt  = 0;
    int                 split_cnt    = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = expected_verdicts.size();
    assign o_checked    = checked_cnt;
    assign o_splits     = split_cnt;

    // verdict of one pair under the given threshold settings
    function automatic t_split_verdict split_verdict_of(t_item p,
                                                        logic [SCORE_W-1:0] brk_set,
                                                        logic [SCORE_W-1:0] mrg_set);
        logic [63:0]    brk, mrg, src, dst, cpy, add, maxsz, removed, score;
        logic [63:0]    full, factor;
        t_split_verdict v;
        full    = 64'(FULL_SCORE);
        factor  = 64'(ADD_FACTOR);
        brk     = (brk_set == '0) ? 64'(DEFAULT_BREAK) : 64'(brk_set);
        mrg     = (mrg_set == '0) ? 64'(DEFAULT_MERGE) : 64'(mrg_set);
        src     = 64'(p.src_size);
        dst     = 64'(p.dst_size);
        cpy     = 64'(p.copied_bytes);
        add     = 64'(p.added_bytes);
        maxsz   = (src > dst) ? src : dst;
        score   = '0;
        v.split = 1'b0;
        if (!p.eligible) begin
            v.split = 1'b0;
        end else if (!p.same_kind) begin
            v.split = 1'b1;
            score   = full;
        end else if (p.same_content || p.data_error || maxsz < 64'(MIN_PAIR_SIZE)
                     || src == '0) begin
            v.split = 1'b0;
        end else begin
            // clamp the copy and literal counts to what the sizes allow
            if (cpy > src)
                cpy = src;
            if (add + cpy > dst)
                add = (cpy < dst) ? dst - cpy : '0;
            removed = src - cpy;
            score   = (removed * full) / src;
            if (score > brk)
                v.split = 1'b1;
            else if (((removed + add) * full) / maxsz < brk)
                v.split = 1'b0;
            else if (src * brk < removed * full && add * factor < removed
                     && add * factor < cpy)
                v.split = 1'b0;     // mostly a removal, hardly anything added
            else
                v.split = 1'b1;
        end
        if (!v.split || score < mrg)
            score = '0;
        v.score = score[SCORE_W-1:0];
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            break_setting = '0;
            merge_setting = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BREAK: break_setting = i_cfg_data;
                    REG_MERGE: merge_setting = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                pair.eligible     = i_s_tuser[0];
                pair.same_kind    = i_s_tuser[1];
                pair.same_content = i_s_tuser[2];
                pair.data_error   = i_s_tuser[3];
                pair.src_size     = i_s_tdata[0*SIZE_W +: SIZE_W];
                pair.dst_size     = i_s_tdata[1*SIZE_W +: SIZE_W];
                pair.copied_bytes = i_s_tdata[2*SIZE_W +: SIZE_W];
                pair.added_bytes  = i_s_tdata[3*SIZE_W +: SIZE_W];
                expected_verdicts.push_back(split_verdict_of(pair, break_setting,
                                                             merge_setting));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result do_break %0b pair_score %0d",
                             $time, i_m_tuser, i_m_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    checked_cnt++;
                    if (i_m_tuser)
                        split_cnt++;
                    if (i_m_tuser !== want.split) begin
                        mismatch_cnt++;
                        $display("%0t: do_break expected %0b got %0b",
                                 $time, want.split, i_m_tuser);
                    end
                    if (i_m_tdata !== want.score) begin
                        mismatch_cnt++;
                        $display("%0t: pair_score expected %0d got %0d",
                                 $time, want.score, i_m_tdata);
                    end
                end
            end
        end
    end

endmodule

### bench/tb_rewrite_break_decision.sv
// testbench top for the rewrite break decision block: drives file pairs and
// threshold writes with random idling and gives the verdict
// depends on rbd_pkg, rewrite_break_decision and rbd_split_checker
module tb_rewrite_break_decision;
    import rbd_pkg::*;

    localparam int PIPE_LATENCY = 22;
    localparam int STALL_LIMIT  = 2000;     // cycles without any transfer
    localparam int PHASES       = 8;
    localparam int PHASE_PAIRS  = 88;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic [FLAG_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SCORE_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCORE_W-1:0]   cfg_data  = '0;

    int mismatches, pending, checked, splits;
    int pairs_sent  = 0;
    int idle_cycles = 0;
    bit steady      = 1'b0;     // both sides run without idling while set

    // threshold settings per phase; the last two phases draw theirs at random
    logic [SCORE_W-1:0] break_plan [PHASES] = '{16'd0, 16'd1, 16'hFFFF, 16'd60000,
                                                 16'd0, 16'd45000, 16'd0, 16'd0};
    logic [SCORE_W-1:0] merge_plan [PHASES] = '{16'd0, 16'd1, 16'hFFFF, 16'd0,
                                                 16'd60000, 16'd20000, 16'd0, 16'd0};

    rewrite_break_decision dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rbd_split_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_splits     (splits)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result sink: a random stall before each result, none in steady phases
    initial begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    function automatic t_item pair_of(logic e, logic k, logic c, logic d,
                                      logic [SIZE_W-1:0] src, logic [SIZE_W-1:0] dst,
                                      logic [SIZE_W-1:0] cpy, logic [SIZE_W-1:0] add);
        t_item p;
        p.eligible     = e;
        p.same_kind    = k;
        p.same_content = c;
        p.data_error   = d;
        p.src_size     = src;
        p.dst_size     = dst;
        p.copied_bytes = cpy;
        p.added_bytes  = add;
        return p;
    endfunction

    // mostly well-formed edits that reach the score tests, some noise
    function automatic t_item random_pair();
        t_item       p;
        int unsigned pick, scale;
        logic [63:0] part;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            p = {4'($urandom), $urandom, $urandom, $urandom, $urandom};
            return p;
        end
        p = pair_of(1'b1, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0);
        if (pick < 17) begin
            case ($urandom_range(0, 3))
                0: p.eligible     = 1'b0;
                1: p.same_kind    = 1'b0;
                2: p.same_content = 1'b1;
                default: p.data_error = 1'b1;
            endcase
        end
        scale = $urandom_range(0, 99);
        if (scale < 55) begin
            p.src_size = $urandom_range(0, 3000);
            p.dst_size = $urandom_range(0, 3000);
        end else if (scale < 65) begin
            // around the minimum pair size
            p.src_size = $urandom_range(380, 420);
            p.dst_size = $urandom_range(0, 420);
        end else if (scale < 85) begin
            p.src_size = $urandom_range(0, 1 << 20);
            p.dst_size = $urandom_range(0, 1 << 20);
        end else begin
            p.src_size = $urandom;
            p.dst_size = $urandom;
        end
        // copied share of the source, now and then beyond it
        part = 64'(p.src_size) * 64'($urandom_range(0, 72)) / 64;
        if (part > 64'hFFFF_FFFF)
            part = 64'hFFFF_FFFF;
        p.copied_bytes = part[SIZE_W-1:0];
        case ($urandom_range(0, 3))
            0: p.added_bytes = p.dst_size / $urandom_range(20, 400);
            1: p.added_bytes = (p.dst_size > p.copied_bytes) ?
                               p.dst_size - p.copied_bytes : '0;
            2: p.added_bytes = p.dst_size - p.copied_bytes + $urandom_range(0, 50);
            default: p.added_bytes = $urandom_range(0, p.dst_size);
        endcase
        return p;
    endfunction

    // one pair transfer; returns on the falling edge after the handshake
    task automatic send_pair(t_item p);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.added_bytes, p.copied_bytes, p.dst_size, p.src_size};
        s_tuser  <= {p.data_error, p.same_content, p.same_kind, p.eligible};
        do @(posedge clk); while (!s_tready);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCORE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drain: every result in, then a further idle wait
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    initial begin
        logic [SCORE_W-1:0] brk, mrg;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pairs under the reset thresholds (both defaults)
        send_pair(pair_of(1'b0, 1'b0, 1'b0, 1'b0, 32'd5000, 32'd5000, '0, '0));
        send_pair(pair_of(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0));
        send_pair(pair_of(1'b1, 1'b1, 1'b1, 1'b0, 32'd1000, 32'd1000, '0, 32'd1000));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b1, 32'd1000, 32'd1000, '0, 32'd1000));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd399, 32'd399, '0, 32'd399));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd400, '0, '0, '0));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, '0, 32'd1000, '0, 32'd1000));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd1000, 32'd1000, 32'd5000, '0));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd1000, 32'd1000, 32'd500, 32'd900));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd2000, 32'd500, 32'd1500, 32'd300));
        // removal only, and the same edit with too much added to be excused
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd100003, 32'd50101, 32'd50001,
                          32'd100));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd100003, 32'd52601, 32'd50001,
                          32'd2600));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd1000, 32'd1000, 32'd100, 32'd900));
        // broken by the edit test, then too small an edit to break
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd1000, 32'd2000, 32'd600, 32'd1400));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd1000, 32'd1000, 32'd900, 32'd100));
        // field extremes
        send_pair(pair_of(1'b1, 1'b1, 1'b1, 1'b1, '1, '1, '1, '1));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, '1, '1, '1, '1));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, '1, '1, '0, '1));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, '1, 32'd1, '0, '0));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0));
        send_pair(pair_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd1, 32'd400, '0, 32'd400));
        wait_idle();

        // random phases, each under its own pair of thresholds
        for (int ph = 0; ph < PHASES; ph++) begin
            brk = (ph >= PHASES - 2) ? SCORE_W'($urandom_range(0, 65535)) : break_plan[ph];
            mrg = (ph >= PHASES - 2) ? SCORE_W'($urandom_range(0, 65535)) : merge_plan[ph];
            write_reg(REG_BREAK, brk);
            write_reg(REG_MERGE, mrg);
            steady = (ph == 2 || ph == 5);
            repeat (PHASE_PAIRS) send_pair(random_pair());
            wait_idle();
        end

        $display("run covered %0d pairs under %0d threshold settings plus the defaults",
                 pairs_sent, PHASES);
        $display("%0d results compared, %0d broken pairs, %0d mismatches",
                 checked, splits, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/rbd_pkg.sv
src/rbd_prep.sv
src/rbd_div_cell.sv
src/rewrite_break_decision.sv
bench/rbd_split_checker.sv
bench/tb_rewrite_break_decision.sv
